[rtl/core/assert_macros.svh]
// Assertion macros shared by the sprite blitter RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_WHEN(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sbas_pkg.sv]
// Package for the sprite blitter: word types, codes, defaults and blend helper.
// No dependencies.
package sbas_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 128;
    localparam int MAX_FRAME_DEF     = 64;
    localparam int MAX_SCALE_DEF     = 8;

    localparam int CW        = 15;
    localparam int SCALE_W   = 4;
    localparam int CNT_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] ALPHA_DRAW   = 8'd128;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd240;
    localparam logic [7:0] ALPHA_FULL   = 8'd255;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;
    localparam logic [6:0]         FW_RESET    = 7'd16;

    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd4;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] col;
        logic [6:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } sbas_in_t;

    typedef struct packed {
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
        logic [6:0] pixels_written;
    } sbas_out_t;

    function automatic logic [7:0] blend_chan(input logic [7:0] src, input logic [7:0] dst,
                                              input logic [7:0] a);
        logic [15:0] sum;
        sum = 16'(src) * 16'(a) + 16'(dst) * 16'(ALPHA_FULL - a);
        return sum[15:8];
    endfunction

endpackage

[rtl/core/sprite_blit_alpha_scale.sv]
// Sprite blitter top level: draw FSM, config registers and the frame store.
// Depends on sbas_pkg and assert_macros.svh.
//
//  channel  | handshake          | word
//  ---------+--------------------+--------------------------------------
//  command  | start && !busy     | cmd    (sbas_in_t)
//  result   | done, one cycle    | result (sbas_out_t)
//  config   | wr_en              | wr_index, wr_data
//
// A draw texel passes SETUP, then SCAN over s*s pixels, where s is the clamped
// scale, then FLUSH: one read-modify-write of the frame store per covered pixel, the
// single memory read port pipelined against its write port.
// Store writes and reads pass ACCESS and RESP; skipped texels and unused modes FINISH.
// Reset restores register defaults; the frame store is undefined until written.
// The result strobe cannot be stalled; busy holds off start while an item is in flight.
`include "assert_macros.svh"

module sprite_blit_alpha_scale #(
    parameter int SCREEN_WIDTH  = sbas_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sbas_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_FRAME     = sbas_pkg::MAX_FRAME_DEF,
    parameter int MAX_SCALE     = sbas_pkg::MAX_SCALE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           wr_en,
    input  logic [sbas_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [sbas_pkg::CFG_W-1:0]     wr_data,
    input  sbas_pkg::sbas_in_t             cmd,
    output logic                           done,
    output sbas_pkg::sbas_out_t            result
);
    import sbas_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);

    typedef enum logic [2:0] {IDLE, SETUP, SCAN, FLUSH, ACCESS, RESP, FINISH} state_t;

    state_t                  state_reg;
    logic signed [11:0]      origin_x_reg;
    logic signed [11:0]      origin_y_reg;
    logic [SCALE_W-1:0]      draw_scale_reg;
    logic                    mirror_reg;
    logic [6:0]              frame_width_reg;

    sbas_in_t                item_reg;
    logic [SCALE_W-1:0]      s_reg;
    logic [6:0]              sx_reg;
    logic signed [CW-1:0]    base_x_reg;
    logic signed [CW-1:0]    base_y_reg;
    logic [SCALE_W-1:0]      px_reg;
    logic [SCALE_W-1:0]      py_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    wv_reg;
    logic [AW-1:0]           w_addr_reg;
    logic [23:0]             rd_data_reg;
    logic                    done_reg;
    sbas_out_t               result_reg;

    logic [23:0]             mem [DEPTH];

    logic                    accept;
    logic [SCALE_W-1:0]      s_clamp;
    logic [6:0]              sx_sel;
    logic                    draw_ok;
    logic [10:0]             prod_x;
    logic [10:0]             prod_y;
    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;
    logic                    scan_in;
    logic [AW-1:0]           scan_addr;
    logic                    scan_last;
    logic                    acc_in;
    logic [AW-1:0]           acc_addr;
    logic [23:0]             blended;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [23:0]             mem_wdata;

    assign busy   = (state_reg != IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && !busy;

    always_comb
    begin
        if (draw_scale_reg == '0)
            s_clamp = SCALE_W'(1);
        else if (int'(draw_scale_reg) > MAX_SCALE)
            s_clamp = SCALE_W'(MAX_SCALE);
        else
            s_clamp = draw_scale_reg;
    end

    assign sx_sel  = mirror_reg ? (frame_width_reg - 7'd1 - cmd.col) : cmd.col;
    assign draw_ok = (cmd.alpha >= ALPHA_DRAW) && (cmd.col < frame_width_reg)
                     && (9'(cmd.row) < 9'(MAX_FRAME));

    assign prod_x = 11'(sx_reg) * 11'(s_reg);
    assign prod_y = 11'(item_reg.row) * 11'(s_reg);

    assign dx        = base_x_reg + CW'(px_reg);
    assign dy        = base_y_reg + CW'(py_reg);
    assign scan_in   = !dx[CW-1] && !dy[CW-1]
                       && ($unsigned(dx) < CW'(SCREEN_WIDTH))
                       && ($unsigned(dy) < CW'(SCREEN_HEIGHT));
    assign scan_addr = AW'(dy[YW-1:0]) * AW'(SCREEN_WIDTH) + AW'(dx[XW-1:0]);
    assign scan_last = (px_reg == s_reg - 1'b1) && (py_reg == s_reg - 1'b1);

    assign acc_in   = (13'(item_reg.col) < 13'(SCREEN_WIDTH))
                      && (13'(item_reg.row) < 13'(SCREEN_HEIGHT));
    assign acc_addr = AW'(item_reg.row) * AW'(SCREEN_WIDTH) + AW'(item_reg.col);

    always_comb
    begin
        if (item_reg.alpha >= ALPHA_OPAQUE)
            blended = {item_reg.red, item_reg.green, item_reg.blue};
        else
            blended = {blend_chan(item_reg.red,   rd_data_reg[23:16], item_reg.alpha),
                       blend_chan(item_reg.green, rd_data_reg[15:8],  item_reg.alpha),
                       blend_chan(item_reg.blue,  rd_data_reg[7:0],   item_reg.alpha)};
    end

    assign mem_re    = ((state_reg == SCAN) && scan_in)
                       || ((state_reg == ACCESS) && (item_reg.mode == MODE_READ) && acc_in);
    assign mem_raddr = (state_reg == SCAN) ? scan_addr : acc_addr;
    assign mem_we    = wv_reg
                       || ((state_reg == ACCESS) && (item_reg.mode == MODE_WRITE) && acc_in);
    assign mem_waddr = wv_reg ? w_addr_reg : acc_addr;
    assign mem_wdata = wv_reg ? blended : {item_reg.red, item_reg.green, item_reg.blue};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            draw_scale_reg  <= SCALE_RESET;
            mirror_reg      <= 1'b0;
            frame_width_reg <= FW_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ORIGIN_X:    origin_x_reg    <= wr_data;
                REG_ORIGIN_Y:    origin_y_reg    <= wr_data;
                REG_DRAW_SCALE:  draw_scale_reg  <= wr_data[SCALE_W-1:0];
                REG_MIRROR:      mirror_reg      <= wr_data[0];
                REG_FRAME_WIDTH: frame_width_reg <= wr_data[6:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
            s_reg    <= s_clamp;
            sx_reg   <= sx_sel;
        end
        if (state_reg == SETUP)
        begin
            base_x_reg <= CW'(origin_x_reg) + $signed(CW'(prod_x));
            base_y_reg <= CW'(origin_y_reg) + $signed(CW'(prod_y));
        end
        if (state_reg == SCAN)
            w_addr_reg <= scan_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            px_reg     <= '0;
            py_reg     <= '0;
            count_reg  <= '0;
            wv_reg     <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    done_reg <= 1'b0;
                    wv_reg   <= 1'b0;
                    if (start)
                    begin
                        px_reg    <= '0;
                        py_reg    <= '0;
                        count_reg <= '0;
                        if ((cmd.mode == MODE_DRAW) && draw_ok)
                            state_reg <= SETUP;
                        else if ((cmd.mode == MODE_WRITE) || (cmd.mode == MODE_READ))
                            state_reg <= ACCESS;
                        else
                            state_reg <= FINISH;
                    end
                end
                SETUP:
                begin
                    done_reg  <= 1'b0;
                    wv_reg    <= 1'b0;
                    state_reg <= SCAN;
                end
                SCAN:
                begin
                    done_reg <= 1'b0;
                    wv_reg   <= scan_in;
                    if (scan_in)
                        count_reg <= count_reg + 1'b1;
                    if (px_reg == s_reg - 1'b1)
                    begin
                        px_reg <= '0;
                        py_reg <= py_reg + 1'b1;
                    end
                    else
                    begin
                        px_reg <= px_reg + 1'b1;
                    end
                    if (scan_last)
                        state_reg <= FLUSH;
                end
                FLUSH:
                begin
                    done_reg   <= 1'b1;
                    wv_reg     <= 1'b0;
                    result_reg <= '{read_red: 8'd0, read_green: 8'd0, read_blue: 8'd0,
                                    pixels_written: count_reg[6:0]};
                    state_reg  <= IDLE;
                end
                ACCESS:
                begin
                    done_reg  <= 1'b0;
                    wv_reg    <= 1'b0;
                    state_reg <= RESP;
                end
                RESP:
                begin
                    done_reg <= 1'b1;
                    wv_reg   <= 1'b0;
                    if ((item_reg.mode == MODE_READ) && acc_in)
                        result_reg <= '{read_red: rd_data_reg[23:16],
                                        read_green: rd_data_reg[15:8],
                                        read_blue: rd_data_reg[7:0],
                                        pixels_written: 7'd0};
                    else
                        result_reg <= '0;
                    state_reg <= IDLE;
                end
                FINISH:
                begin
                    done_reg   <= 1'b1;
                    wv_reg     <= 1'b0;
                    result_reg <= '0;
                    state_reg  <= IDLE;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    wv_reg    <= 1'b0;
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
    `ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "result strobe longer than one cycle")
    `ASSERT_WHEN(a_wstage_state, wv_reg, state_reg == SCAN || state_reg == FLUSH, "stray write")
    `ASSERT_WHEN(a_count_bound, busy, count_reg <= CNT_W'(s_reg) * CNT_W'(s_reg), "count overrun")

endmodule
